/* rtl/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg: battery charge estimator shared definitions
// Field widths, voltage band limits, window lengths, reciprocal constants for
// the divide-by-5 steps and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    // field and state widths
    localparam int unsigned MV_W    = 13;
    localparam int unsigned PCT_W   = 8;
    localparam int unsigned DB_W    = 6;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned PSUM_W  = 11;
    localparam int unsigned MSUM_W  = 18;
    localparam int unsigned AVG_W   = 9;

    // stream payload widths, rounded up to whole bytes
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    // voltage band limits in mV
    localparam logic [MV_W-1:0] FULL_MV      = MV_W'(4100);
    localparam logic [MV_W-1:0] UPPER_MV     = MV_W'(3960);
    localparam logic [MV_W-1:0] MIDDLE_MV    = MV_W'(3220);
    localparam logic [MV_W-1:0] LOWER_MV     = MV_W'(3020);
    localparam logic [MV_W-1:0] UPPER_OFS_MV = MV_W'(3340);
    localparam logic [MV_W-1:0] MID_OFS_MV   = MV_W'(3150);

    // fixed percents of the outer bands
    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_LOW   = PCT_W'(5);
    localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(1);
    localparam logic [PCT_W-1:0] PCT_UNMEASURED = PCT_W'(8'hbc);

    // middle band: floor(d*100/1043) == (d * MID_MULT) >> MID_SHIFT for d < 1024
    localparam int unsigned MID_OFS_W = 10;
    localparam int unsigned MID_MULT_W = 17;
    localparam int unsigned MID_SHIFT = 20;
    localparam logic [MID_MULT_W-1:0] MID_MULT = MID_MULT_W'(100535);

    // divide by 5: exact for the full width of each sum
    localparam int unsigned DIVP_MULT_W = 12;
    localparam int unsigned DIVP_SHIFT  = 14;
    localparam logic [DIVP_MULT_W-1:0] DIVP_MULT = DIVP_MULT_W'(3277);
    localparam int unsigned DIVM_MULT_W = 18;
    localparam int unsigned DIVM_SHIFT  = 20;
    localparam logic [DIVM_MULT_W-1:0] DIVM_MULT = DIVM_MULT_W'(209716);

    // window ends (count after increment) and register reset
    localparam logic [CNT_W-1:0] BURST_END  = CNT_W'(6);
    localparam logic [CNT_W-1:0] NORMAL_END = CNT_W'(21);
    localparam logic [DB_W-1:0]  DEADBAND_RESET = DB_W'(5);

    // one accepted sample
    typedef struct packed {
        logic            cmd;
        logic [MV_W-1:0] cell_mv;
    } t_sample;

    // one result item
    typedef struct packed {
        logic [PCT_W-1:0] display_percent;
        logic [MV_W-1:0]  average_mv;
        logic             refreshed;
    } t_result;

endpackage

`default_nettype wire

/* rtl/bce_percent.sv */
// ----------------------------------------------------------------------------
// bce_percent: cell voltage to charge percent
// Five-band mapping of one sample; the middle band uses a constant
// reciprocal multiply in place of the divide by 1043.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_percent import bce_pkg::*; (
    input  wire logic [MV_W-1:0]  i_cell_mv,
    output logic      [PCT_W-1:0] o_percent
);

    logic [MV_W-1:0]                   upper_ofs;
    logic [MV_W-1:0]                   mid_ofs_full;
    logic [MID_OFS_W-1:0]              mid_ofs;
    logic [MID_OFS_W+MID_MULT_W-1:0]   mid_prod;

    // band offsets; only meaningful inside their own band
    assign upper_ofs    = i_cell_mv - UPPER_OFS_MV;
    assign mid_ofs_full = i_cell_mv - MID_OFS_MV;
    assign mid_ofs      = mid_ofs_full[MID_OFS_W-1:0];
    assign mid_prod     = mid_ofs * MID_MULT;

    // band select
    always_comb begin
        if (i_cell_mv >= FULL_MV) begin
            o_percent = PCT_FULL;
        end else if (i_cell_mv >= UPPER_MV) begin
            o_percent = upper_ofs[PCT_W+2:3];
        end else if (i_cell_mv >= MIDDLE_MV) begin
            o_percent = PCT_W'(mid_prod[MID_OFS_W+MID_MULT_W-1:MID_SHIFT]);
        end else if (i_cell_mv >= LOWER_MV) begin
            o_percent = PCT_LOW;
        end else begin
            o_percent = PCT_EMPTY;
        end
    end

endmodule

`default_nettype wire

/* rtl/bce_window.sv */
// ----------------------------------------------------------------------------
// bce_window: averaging windows and display update
// Holds mode, sample count, running sums and the shown values; on each step
// it accumulates a sample or closes a window and decides on a refresh.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_window import bce_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_sample          i_sample,
    input  wire logic [PCT_W-1:0] i_percent,
    input  wire logic [DB_W-1:0]  i_deadband,
    output t_result               o_result
);

    logic              r_burst, n_burst;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PSUM_W-1:0] r_psum, n_psum;
    logic [MSUM_W-1:0] r_msum, n_msum;
    logic [PCT_W-1:0]  r_shown_pct, n_shown_pct;
    logic [MV_W-1:0]   r_shown_mv, n_shown_mv;

    logic                          burst_now;
    logic [CNT_W-1:0]              count_base;
    logic [CNT_W-1:0]              count_inc;
    logic                          burst_end;
    logic                          normal_end;
    logic [PSUM_W-1:0]             psum_q;
    logic [MSUM_W-1:0]             msum_q;
    logic [PSUM_W+DIVP_MULT_W-1:0] pavg_prod;
    logic [MSUM_W+DIVM_MULT_W-1:0] mavg_prod;
    logic [AVG_W-1:0]              avg;
    logic [AVG_W-1:0]              shown_ext;
    logic [AVG_W-1:0]              db_ext;
    logic [AVG_W-1:0]              rise_diff;
    logic [AVG_W-1:0]              drop_diff;
    logic                          avg_up;
    logic                          avg_down;
    logic                          burst_take;
    logic                          normal_take;
    logic                          take;

    // mode and count after the command
    assign burst_now  = i_sample.cmd | r_burst;
    assign count_base = i_sample.cmd ? '0 : r_count;
    assign count_inc  = count_base + CNT_W'(1);
    assign burst_end  = burst_now && (count_inc > BURST_END);
    assign normal_end = !burst_now && (count_inc > NORMAL_END);

    // window average: /5 in burst, /20 as (/4)/5 in normal mode
    assign psum_q    = burst_now ? r_psum : (r_psum >> 2);
    assign msum_q    = burst_now ? r_msum : (r_msum >> 2);
    assign pavg_prod = psum_q * DIVP_MULT;
    assign mavg_prod = msum_q * DIVM_MULT;
    assign avg       = AVG_W'(pavg_prod[PSUM_W+DIVP_MULT_W-1:DIVP_SHIFT]);

    // compare against the shown percent
    assign shown_ext = AVG_W'(r_shown_pct);
    assign db_ext    = AVG_W'(i_deadband);
    assign avg_up    = avg > shown_ext;
    assign avg_down  = avg < shown_ext;
    assign rise_diff = avg - shown_ext;
    assign drop_diff = shown_ext - avg;

    // burst rises freely, normal drops freely; the other way waits for the deadband
    assign burst_take  = avg_up || (r_shown_pct > PCT_FULL) ||
                         (avg_down && (drop_diff > db_ext));
    assign normal_take = (avg_up && (rise_diff > db_ext)) || avg_down;
    assign take        = (burst_end && burst_take) || (normal_end && normal_take);

    // next state
    always_comb begin
        n_burst     = burst_now;
        n_count     = count_inc;
        n_psum      = r_psum;
        n_msum      = r_msum;
        n_shown_pct = r_shown_pct;
        n_shown_mv  = r_shown_mv;
        if (burst_end || normal_end) begin
            n_count = '0;
            if (burst_end) begin
                n_burst = 1'b0;
            end
        end else if (count_inc == CNT_W'(1)) begin
            n_psum = '0;
            n_msum = '0;
        end else begin
            n_psum = r_psum + PSUM_W'(i_percent);
            n_msum = r_msum + MSUM_W'(i_sample.cell_mv);
        end
        if (take) begin
            n_shown_pct = avg[PCT_W-1:0];
            n_shown_mv  = mavg_prod[DIVM_SHIFT+MV_W-1:DIVM_SHIFT];
        end
    end

    // result of this step
    assign o_result.display_percent = n_shown_pct;
    assign o_result.average_mv      = n_shown_mv;
    assign o_result.refreshed       = take;

    // control and shown values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst     <= 1'b0;
            r_count     <= '0;
            r_shown_pct <= PCT_UNMEASURED;
            r_shown_mv  <= '0;
        end else if (i_step) begin
            r_burst     <= n_burst;
            r_count     <= n_count;
            r_shown_pct <= n_shown_pct;
            r_shown_mv  <= n_shown_mv;
        end
    end

    // running sums, cleared by the first sample of every window
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_psum <= n_psum;
            r_msum <= n_msum;
        end
    end

endmodule

`default_nettype wire

/* rtl/battery_charge_estimator.sv */
// ----------------------------------------------------------------------------
// battery_charge_estimator: windowed cell voltage to charge percent
// Maps voltage samples to percent, averages them over burst or normal
// windows and keeps the displayed percent and its averaged millivolts.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per transfer: tdata holds the cell voltage in
//   mV, tuser[0] is the command (1 starts a five-sample burst refresh).
//   m_axis returns one result per sample: tdata holds the shown percent and
//   the averaged mV, tuser[0] flags that this sample changed the display.
//   i_cfg_we writes the 6-bit deadband from i_cfg_wdata; write it only while
//   no sample is in flight.
//   Throughput is one sample per cycle while the receiver does not stall. A
//   sample passes through the input register, then through the percent
//   mapping and window update into the result register.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more sample before s_axis_tready drops.
//   Reset empties both registers, returns to normal mode with an empty
//   window, shows 188 (not yet measured) with 0 mV, and sets the deadband
//   to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_estimator import bce_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [12:0] cell_mv
    input  wire logic [0:0]             s_axis_tuser,   // [0] cmd
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [7:0] display_percent,
                                                        // [20:8] average_mv
    output logic [0:0]                  m_axis_tuser,   // [0] refreshed
    // deadband register
    input  wire logic                   i_cfg_we,
    input  wire logic [DB_W-1:0]        i_cfg_wdata
);

    logic             r_deadband;
    logic [DB_W-1:0]  r_deadband_val;
    logic             r_in_valid;
    t_sample          r_in;
    logic             r_out_valid;
    t_result          r_out;
    logic             out_free;
    logic             step;
    logic             in_xfer;
    logic [PCT_W-1:0] sample_pct;
    t_result          step_result;

    // handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // deadband register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband     <= 1'b1;
            r_deadband_val <= DEADBAND_RESET;
        end else if (i_cfg_we) begin
            r_deadband     <= 1'b1;
            r_deadband_val <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.cmd     <= s_axis_tuser[0];
            r_in.cell_mv <= s_axis_tdata[MV_W-1:0];
        end
    end

    // percent of the held sample
    bce_percent u_percent (
        .i_cell_mv (r_in.cell_mv),
        .o_percent (sample_pct)
    );

    // window state and display decision
    bce_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_sample   (r_in),
        .i_percent  (sample_pct),
        .i_deadband (r_deadband ? r_deadband_val : DEADBAND_RESET),
        .o_result   (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-MV_W-PCT_W){1'b0}},
                            r_out.average_mv, r_out.display_percent};
    assign m_axis_tuser  = r_out.refreshed;

endmodule

`default_nettype wire

/* rtl/bce_checker.sv */
// ----------------------------------------------------------------------------
// bce_checker: port-level checks for the charge estimator
// Watches the top-level ports for result stream stability, reset behavior
// and the legal range of the shown values.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_checker import bce_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [0:0]            m_axis_tuser
);

    logic [PCT_W-1:0] shown_pct;
    logic [MV_W-1:0]  shown_mv;
    logic             in_xfer;

    assign shown_pct = m_axis_tdata[PCT_W-1:0];
    assign shown_mv  = m_axis_tdata[PCT_W+MV_W-1:PCT_W];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an input transfer while the receiver stays ready is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && m_axis_tready ##1 m_axis_tready && i_rst_n |=> m_axis_tvalid)
        else $error("result missing after input transfer");

    // the shown percent is a real percent or the unmeasured mark
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (shown_pct <= PCT_FULL) || (shown_pct == PCT_UNMEASURED))
        else $error("shown percent out of range");

    // no averaged millivolts before the first measurement
    a_unmeasured_mv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (shown_pct == PCT_UNMEASURED) |-> (shown_mv == '0) &&
            !m_axis_tuser[0])
        else $error("millivolts shown while unmeasured");

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: battery charge estimator testbench
// Drives cell-voltage samples and burst commands into the sample stream and
// predicts every result in a scoreboard that tracks the windows, the shown
// percent and its averaged millivolts. Phases vary the deadband and the
// stalling on both streams, with long receiver hold-offs to fill the block.
// ----------------------------------------------------------------------------
module tb_top;
    import bce_pkg::*;

    // sample commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_BURST  = 1'b1;

    // voltage bands and window shape
    localparam int BAND_FULL   = 4100;
    localparam int BAND_UPPER  = 3960;
    localparam int BAND_MIDDLE = 3220;
    localparam int BAND_LOWER  = 3020;
    localparam int BURST_LAST  = 6;
    localparam int BURST_SPAN  = 5;
    localparam int NORMAL_LAST = 21;
    localparam int NORMAL_SPAN = 20;
    localparam int NOT_MEASURED = 188;
    localparam int DEADBAND_AT_RESET = 5;

    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 175;

    // expected display per sample, with its own copy of the window state
    class display_scoreboard;
        t_result          pending_displays[$];
        logic             burst;
        logic [4:0]       count;
        logic [10:0]      pct_sum;
        logic [17:0]      mv_sum;
        logic [PCT_W-1:0] shown_pct;
        logic [MV_W-1:0]  shown_mv;
        logic [DB_W-1:0]  deadband;
        int failures;
        int samples;
        int results;
        int burst_ends;
        int normal_ends;
        int refreshes;

        function new();
            burst       = 1'b0;
            count       = '0;
            pct_sum     = '0;
            mv_sum      = '0;
            shown_pct   = PCT_W'(NOT_MEASURED);
            shown_mv    = '0;
            deadband    = DB_W'(DEADBAND_AT_RESET);
            failures    = 0;
            samples     = 0;
            results     = 0;
            burst_ends  = 0;
            normal_ends = 0;
            refreshes   = 0;
        endfunction

        function void write_deadband(logic [DB_W-1:0] value);
            deadband = value;
        endfunction

        function int pending();
            return pending_displays.size();
        endfunction

        // charge percent of one sample
        function int mv_percent(logic [MV_W-1:0] v);
            int mv;
            mv = v;
            if (mv >= BAND_FULL) return 100;
            if (mv >= BAND_UPPER) return (mv - 3340) / 8;
            if (mv >= BAND_MIDDLE) return ((mv - 3150) * 100) / 1043;
            if (mv >= BAND_LOWER) return 5;
            return 1;
        endfunction

        // accepted sample: advance the window and queue the expected display
        function void note_sample(logic cmd, logic [MV_W-1:0] mv);
            t_result exp_r;
            int avg;
            int shown;
            int db;
            exp_r.refreshed = 1'b0;
            shown = shown_pct;
            db = deadband;
            samples++;
            if (cmd == CMD_BURST) begin
                burst = 1'b1;
                count = '0;
            end
            count = count + 5'd1;
            if (burst && count > BURST_LAST) begin
                avg = pct_sum / BURST_SPAN;
                burst = 1'b0;
                count = '0;
                burst_ends++;
                // burst: rise, leave the unmeasured state, or drop past the deadband
                if (avg > shown || shown > 100 || (avg < shown && shown - avg > db)) begin
                    shown_pct = PCT_W'(avg);
                    shown_mv = MV_W'(mv_sum / BURST_SPAN);
                    exp_r.refreshed = 1'b1;
                end
            end else if (!burst && count > NORMAL_LAST) begin
                avg = pct_sum / NORMAL_SPAN;
                count = '0;
                normal_ends++;
                // normal: rise past the deadband or drop by any amount
                if ((avg > shown && avg - shown > db) || avg < shown) begin
                    shown_pct = PCT_W'(avg);
                    shown_mv = MV_W'(mv_sum / NORMAL_SPAN);
                    exp_r.refreshed = 1'b1;
                end
            end else if (count == 5'd1) begin
                pct_sum = '0;
                mv_sum = '0;
            end else begin
                mv_sum = mv_sum + 18'(mv);
                pct_sum = pct_sum + 11'(mv_percent(mv));
            end
            if (exp_r.refreshed) refreshes++;
            exp_r.display_percent = shown_pct;
            exp_r.average_mv = shown_mv;
            pending_displays.push_back(exp_r);
        endfunction

        // result transfer against the oldest expectation
        function void check_display(t_result got);
            t_result exp_r;
            if (pending_displays.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: percent %0d mv %0d refreshed %0b",
                             got.display_percent, got.average_mv, got.refreshed);
                return;
            end
            exp_r = pending_displays.pop_front();
            results++;
            if (got.display_percent !== exp_r.display_percent ||
                got.average_mv !== exp_r.average_mv ||
                got.refreshed !== exp_r.refreshed) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d mismatch: percent exp %0d got %0d, mv exp %0d got %0d, refreshed exp %0b got %0b",
                             results, exp_r.display_percent, got.display_percent,
                             exp_r.average_mv, got.average_mv,
                             exp_r.refreshed, got.refreshed);
            end
        endfunction

        function void check_leftover();
            if (pending_displays.size() != 0) begin
                failures++;
                $display("%0d expected results never arrived", pending_displays.size());
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [12:0] cell_mv
    logic [0:0]             s_axis_tuser = '0;    // [0] cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] display_percent, [20:8] average_mv
    logic [0:0]             m_axis_tuser;         // [0] refreshed
    logic                   i_cfg_we = 1'b0;
    logic [DB_W-1:0]        i_cfg_wdata = '0;

    display_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int cycle_count = 0;

    battery_charge_estimator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitor both streams, input transfer noted before the result check
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tuser[0], s_axis_tdata[MV_W-1:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                got.display_percent = m_axis_tdata[PCT_W-1:0];
                got.average_mv = m_axis_tdata[PCT_W+MV_W-1:PCT_W];
                got.refreshed = m_axis_tuser[0];
                sb.check_display(got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                hold_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // one sample transfer; starts and ends just after a falling edge
    task automatic send_sample(input logic cmd, input logic [MV_W-1:0] mv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(mv);
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender pauses until every expected result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_deadband(input logic [DB_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_deadband(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly inside the interesting bands, sometimes anywhere
    function automatic int pick_level();
        if ($urandom_range(9) == 0) return $urandom_range(8191);
        return $urandom_range(4300, 2850);
    endfunction

    function automatic logic [MV_W-1:0] near_level(int lvl);
        int v;
        v = lvl + int'($urandom_range(80)) - 40;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
        return MV_W'(v);
    endfunction

    // burst refreshes, steady runs and noise with broken windows
    task automatic run_random(input int total);
        int sent;
        int kind;
        int lvl;
        int n;
        int k;
        sent = 0;
        while (sent < total) begin
            kind = $urandom_range(99);
            lvl = pick_level();
            if (kind < 20) begin
                send_sample(CMD_BURST, near_level(lvl));
                for (k = 0; k < BURST_LAST; k++) send_sample(CMD_SAMPLE, near_level(lvl));
                sent += BURST_LAST + 1;
            end else if (kind < 75) begin
                for (k = 0; k <= NORMAL_LAST; k++) send_sample(CMD_SAMPLE, near_level(lvl));
                sent += NORMAL_LAST + 1;
            end else begin
                n = $urandom_range(5, 1);
                for (k = 0; k < n; k++)
                    send_sample(($urandom_range(3) == 0) ? CMD_BURST : CMD_SAMPLE,
                                MV_W'($urandom_range(8191)));
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: band edges, first burst out of the unmeasured state
        send_sample(CMD_BURST, 13'd3020);
        send_sample(CMD_SAMPLE, 13'd4100);
        send_sample(CMD_SAMPLE, 13'd4099);
        send_sample(CMD_SAMPLE, 13'd3960);
        send_sample(CMD_SAMPLE, 13'd3959);
        send_sample(CMD_SAMPLE, 13'd3220);
        send_sample(CMD_SAMPLE, 13'd3219);
        // low edges and field extremes, drop past the deadband
        send_sample(CMD_BURST, 13'd0);
        send_sample(CMD_SAMPLE, 13'd3219);
        send_sample(CMD_SAMPLE, 13'd3020);
        send_sample(CMD_SAMPLE, 13'd3019);
        send_sample(CMD_SAMPLE, 13'd0);
        send_sample(CMD_SAMPLE, 13'd8191);
        send_sample(CMD_SAMPLE, 13'd8191);
        // burst restarted in the middle of a burst
        send_sample(CMD_BURST, 13'd3500);
        send_sample(CMD_SAMPLE, 13'd3600);
        send_sample(CMD_BURST, 13'd3700);
        send_sample(CMD_SAMPLE, 13'd3800);
        send_sample(CMD_SAMPLE, 13'd3900);
        send_sample(CMD_SAMPLE, 13'd4000);
        send_sample(CMD_SAMPLE, 13'd4050);
        send_sample(CMD_SAMPLE, 13'd4200);
        send_sample(CMD_SAMPLE, 13'd5000);
        wait_drained();

        // no idling, zero deadband, long hold-off while the sender keeps going
        set_deadband(6'd0);
        hold_req++;
        run_random(PHASE_ITEMS);
        wait_drained();

        // idle sender, widest deadband
        set_deadband(6'd63);
        send_idle_pct = 77;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        // stalling receiver
        set_deadband(DB_W'($urandom_range(62, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 77;
        run_random(PHASE_ITEMS);
        wait_drained();

        // both sides idle, another hold-off
        set_deadband(DB_W'($urandom_range(20, 1)));
        send_idle_pct = 35;
        recv_stall_pct = 35;
        hold_req++;
        run_random(PHASE_ITEMS);
        wait_drained();
        repeat (10) @(negedge i_clk);

        sb.check_leftover();
        $display("covered %0d samples and %0d results: %0d burst and %0d normal window ends,",
                 sb.samples, sb.results, sb.burst_ends, sb.normal_ends);
        $display("%0d display refreshes, deadband 0, 5, 63 and random, %0d mismatches",
                 sb.refreshes, sb.failures);
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
